>>> hdl/bsfr_pkg.sv
// shared types and constants of the byte stuffing frame receiver
// no dependencies; imported by bsfr_cfg_regs, byte_stuffing_frame_receiver and the testbench
`default_nettype none

package bsfr_pkg;

  localparam int CFG_ADDR_W = 5;

  localparam logic [2:0] REG_BEGIN_MARKER      = 3'd0;
  localparam logic [2:0] REG_END_MARKER        = 3'd1;
  localparam logic [2:0] REG_ESCAPE_MARKER     = 3'd2;
  localparam logic [2:0] REG_BEGIN_SUBSTITUTE  = 3'd3;
  localparam logic [2:0] REG_END_SUBSTITUTE    = 3'd4;
  localparam logic [2:0] REG_ESCAPE_SUBSTITUTE = 3'd5;

  localparam logic [7:0] RST_BEGIN_MARKER      = 8'd64;
  localparam logic [7:0] RST_END_MARKER        = 8'd13;
  localparam logic [7:0] RST_ESCAPE_MARKER     = 8'd10;
  localparam logic [7:0] RST_BEGIN_SUBSTITUTE  = 8'd130;
  localparam logic [7:0] RST_END_SUBSTITUTE    = 8'd131;
  localparam logic [7:0] RST_ESCAPE_SUBSTITUTE = 8'd132;

  typedef struct packed {
    logic [7:0] begin_marker;
    logic [7:0] end_marker;
    logic [7:0] escape_marker;
    logic [7:0] begin_substitute;
    logic [7:0] end_substitute;
    logic [7:0] escape_substitute;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_RECV = 2'd1,
    ST_DONE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_STORED   = 3'd1,
    EV_OVERFLOW = 3'd2,
    EV_BADESC   = 3'd3,
    EV_IGNORED  = 3'd4,
    EV_READ     = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    ACT_LINE    = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_READ    = 2'd2
  } action_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    event_t     event_res;
    logic [8:0] frame_length;
    status_t    frame_status;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/byte_stuffing_frame_receiver.sv
// top level of the byte stuffing frame receiver: unstuffing, frame store, result pipeline
// depends on bsfr_pkg and bsfr_cfg_regs
`default_nettype none

// Takes one item per clock cycle at full rate when the output side is ready and returns
// exactly one result item for each. Line bytes are unstuffed with the programmable markers
// and substitute codes and written into a frame store of STORE_DEPTH bytes; read items fetch
// a stored byte. The store is a memory with one write port and one registered read port:
// the first register stage holds the decoded result and the read data, the second is the
// output register, so a new item is taken while a finished result still waits. The store
// has no reset and no clearing pass; entries are valid once written. Registers are to be
// written only while idle; the block itself does not enforce this.
module byte_stuffing_frame_receiver #(
  parameter int STORE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  // apb-style configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bsfr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [15:0]                      s_tdata,  // line_byte[7:0], read_index[15:8]
  input  logic [1:0]                       s_tuser,  // action[1:0]
  // result items
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [23:0]                      m_tdata,  // frame_status[1:0], frame_length[10:2],
                                                     // data_byte[18:11], zeros[23:19]
  output logic [3:0]                       m_tuser   // event_res[2:0], data_valid[3]
);
  import bsfr_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PW = $clog2(STORE_DEPTH + 1);

  cfg_t cfg;

  bsfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // receiver state
  status_t         status, status_next;
  logic            esc_pending, esc_pending_next;
  logic [PW-1:0]   wpos, wpos_next;

  logic [7:0]      store_mem [STORE_DEPTH];
  logic [7:0]      rd_data;

  // decode of the incoming item
  action_t         action;
  logic [7:0]      line_byte;
  logic [7:0]      read_index;
  logic            s_fire;
  logic            is_begin, is_end, is_escape, is_full;
  logic            sub_begin, sub_end, sub_escape, bad_escape;
  logic [7:0]      unstuffed;
  logic            do_store;
  logic            rd_in_range;
  logic [AW-1:0]   rd_addr;

  // pipeline
  logic            v1, v2, advance1;
  result_t         res1_next, res1, res2;
  logic            rd_pick1;

  assign action     = action_t'(s_tuser);
  assign line_byte  = s_tdata[7:0];
  assign read_index = s_tdata[15:8];
  assign s_fire     = s_tvalid && s_tready;

  assign is_begin   = line_byte == cfg.begin_marker;
  assign is_end     = line_byte == cfg.end_marker;
  assign is_escape  = line_byte == cfg.escape_marker;
  assign is_full    = wpos == PW'(STORE_DEPTH);
  assign sub_begin  = line_byte == cfg.begin_substitute;
  assign sub_end    = line_byte == cfg.end_substitute;
  assign sub_escape = line_byte == cfg.escape_substitute;
  assign bad_escape = esc_pending && !sub_begin && !sub_end && !sub_escape;

  always_comb begin
    if (!esc_pending)    unstuffed = line_byte;
    else if (sub_begin)  unstuffed = cfg.begin_marker;
    else if (sub_end)    unstuffed = cfg.end_marker;
    else                 unstuffed = cfg.escape_marker;
  end

  assign do_store = s_fire && action == ACT_LINE && status != ST_DONE && !is_begin
                    && !is_end && !is_escape && !is_full && !bad_escape;

  assign rd_in_range = 32'(read_index) < 32'(STORE_DEPTH);
  assign rd_addr     = AW'(read_index);

  // next state
  always_comb begin
    status_next      = status;
    esc_pending_next = esc_pending;
    wpos_next        = wpos;
    unique case (action)
      ACT_LINE: begin
        if (status == ST_DONE) begin
          status_next = status;
        end else if (is_begin) begin
          status_next      = ST_RECV;
          wpos_next        = '0;
          esc_pending_next = 1'b0;
        end else if (is_end) begin
          status_next = ST_DONE;
        end else if (is_escape) begin
          esc_pending_next = 1'b1;
        end else if (is_full) begin
          status_next = ST_IDLE;
        end else if (bad_escape) begin
          status_next      = ST_IDLE;
          esc_pending_next = 1'b0;
        end else begin
          esc_pending_next = 1'b0;
          wpos_next        = wpos + 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (status == ST_DONE) status_next = ST_IDLE;
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    res1_next.event_res  = EV_NONE;
    res1_next.data_valid = 1'b0;
    res1_next.data_byte  = 8'd0;
    unique case (action)
      ACT_LINE: begin
        if (status == ST_DONE) begin
          res1_next.event_res = EV_IGNORED;
        end else if (is_begin || is_end || is_escape) begin
          res1_next.event_res = EV_NONE;
        end else if (is_full) begin
          res1_next.event_res = EV_OVERFLOW;
        end else if (bad_escape) begin
          res1_next.event_res = EV_BADESC;
        end else begin
          res1_next.event_res  = EV_STORED;
          res1_next.data_valid = 1'b1;
          res1_next.data_byte  = unstuffed;
        end
      end
      ACT_READ: begin
        res1_next.event_res  = EV_READ;
        res1_next.data_valid = rd_in_range;
      end
      default: ;
    endcase
    res1_next.frame_status = status_next;
    res1_next.frame_length = 9'(wpos_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status      <= ST_IDLE;
      esc_pending <= 1'b0;
      wpos        <= '0;
    end else if (s_fire) begin
      status      <= status_next;
      esc_pending <= esc_pending_next;
      wpos        <= wpos_next;
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (do_store) store_mem[AW'(wpos)] <= unstuffed;
    if (s_fire) rd_data <= store_mem[rd_addr];
  end

  // two-stage result pipeline
  assign advance1 = v1 && (!v2 || m_tready);
  assign s_tready = !v1 || advance1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (s_fire)        v1 <= 1'b1;
      else if (advance1) v1 <= 1'b0;
      if (advance1)      v2 <= 1'b1;
      else if (m_tready) v2 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      res1     <= res1_next;
      rd_pick1 <= action == ACT_READ && rd_in_range;
    end
    if (advance1) begin
      res2.frame_status <= res1.frame_status;
      res2.frame_length <= res1.frame_length;
      res2.event_res    <= res1.event_res;
      res2.data_valid   <= res1.data_valid;
      res2.data_byte    <= rd_pick1 ? rd_data : res1.data_byte;
    end
  end

  assign m_tvalid = v2;
  assign m_tdata  = {5'd0, res2.data_byte, res2.frame_length, res2.frame_status};
  assign m_tuser  = {res2.data_valid, res2.event_res};

  // checks
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_wpos_bound: assert property (@(posedge clk) disable iff (rst)
    32'(wpos) <= 32'(STORE_DEPTH))
    else $error("write position beyond store depth");

  a_begin_clears_escape: assert property (@(posedge clk) disable iff (rst)
    s_fire && action == ACT_LINE && status != ST_DONE && is_begin
    |=> !esc_pending && wpos == '0 && status == ST_RECV)
    else $error("begin marker did not restart the frame");

endmodule

`default_nettype wire

>>> hdl/bsfr_cfg_regs.sv
// configuration register file of the byte stuffing frame receiver
// apb-style slave; depends on bsfr_pkg
`default_nettype none

module bsfr_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bsfr_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output bsfr_pkg::cfg_t                   cfg
);
  import bsfr_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.begin_marker      <= RST_BEGIN_MARKER;
      cfg.end_marker        <= RST_END_MARKER;
      cfg.escape_marker     <= RST_ESCAPE_MARKER;
      cfg.begin_substitute  <= RST_BEGIN_SUBSTITUTE;
      cfg.end_substitute    <= RST_END_SUBSTITUTE;
      cfg.escape_substitute <= RST_ESCAPE_SUBSTITUTE;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BEGIN_MARKER:      cfg.begin_marker      <= pwdata[7:0];
        REG_END_MARKER:        cfg.end_marker        <= pwdata[7:0];
        REG_ESCAPE_MARKER:     cfg.escape_marker     <= pwdata[7:0];
        REG_BEGIN_SUBSTITUTE:  cfg.begin_substitute  <= pwdata[7:0];
        REG_END_SUBSTITUTE:    cfg.end_substitute    <= pwdata[7:0];
        REG_ESCAPE_SUBSTITUTE: cfg.escape_substitute <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BEGIN_MARKER:      prdata = {24'd0, cfg.begin_marker};
      REG_END_MARKER:        prdata = {24'd0, cfg.end_marker};
      REG_ESCAPE_MARKER:     prdata = {24'd0, cfg.escape_marker};
      REG_BEGIN_SUBSTITUTE:  prdata = {24'd0, cfg.begin_substitute};
      REG_END_SUBSTITUTE:    prdata = {24'd0, cfg.end_substitute};
      REG_ESCAPE_SUBSTITUTE: prdata = {24'd0, cfg.escape_substitute};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> bench/tb_byte_stuffing_frame_receiver.sv
// testbench of the byte stuffing frame receiver: directed items, store overflow, register
// settings, back-pressure and random frame traffic, each result checked against a predictor
// depends on bsfr_pkg and byte_stuffing_frame_receiver
`default_nettype none

module tb_byte_stuffing_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import bsfr_pkg::*;

  localparam int DEPTH = 256;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 700;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum {SET_DEFAULT, SET_ZEROS, SET_ONES, SET_EXTREMES, SET_RANDOM} setting_t;
  typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} ready_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [15:0]           s_tdata;  // line_byte[7:0], read_index[15:8]
  logic [1:0]            s_tuser;  // action[1:0]
  logic                  m_tvalid;
  logic                  m_tready;
  logic [23:0]           m_tdata;  // frame_status[1:0], frame_length[10:2], data_byte[18:11]
  logic [3:0]            m_tuser;  // event_res[2:0], data_valid[3]

  // predictor state
  cfg_t        rx_cfg;
  status_t     rx_status;
  logic        rx_escape;
  int unsigned rx_pos;
  int unsigned rx_filled;
  logic [7:0]  rx_mem [DEPTH];

  result_t pending_results [$];
  int      mismatches;
  int      items_sent;
  int      burst_left;
  bit      steady_sender;
  int      holdoff_requests;
  int      idle_cycles = 0;

  byte_stuffing_frame_receiver #(
    .STORE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic result_t predict_frame_result(logic [1:0] act, logic [7:0] lb,
                                                   logic [7:0] ri);
    result_t r;
    logic [7:0] b;
    logic code_ok;
    r = '0;
    r.event_res = EV_NONE;
    b = lb;
    code_ok = 1'b1;
    case (act)
      ACT_LINE: begin
        if (rx_status == ST_DONE) begin
          r.event_res = EV_IGNORED;
        end else if (lb == rx_cfg.begin_marker) begin
          rx_status = ST_RECV;
          rx_pos = 0;
          rx_escape = 1'b0;
        end else if (lb == rx_cfg.end_marker) begin
          rx_status = ST_DONE;
        end else if (lb == rx_cfg.escape_marker) begin
          rx_escape = 1'b1;
        end else if (rx_pos >= DEPTH) begin
          rx_status = ST_IDLE;
          r.event_res = EV_OVERFLOW;
        end else begin
          if (rx_escape) begin
            if (lb == rx_cfg.begin_substitute) b = rx_cfg.begin_marker;
            else if (lb == rx_cfg.end_substitute) b = rx_cfg.end_marker;
            else if (lb == rx_cfg.escape_substitute) b = rx_cfg.escape_marker;
            else code_ok = 1'b0;
          end
          rx_escape = 1'b0;
          if (!code_ok) begin
            rx_status = ST_IDLE;
            r.event_res = EV_BADESC;
          end else begin
            rx_mem[rx_pos] = b;
            rx_pos++;
            if (rx_pos > rx_filled) rx_filled = rx_pos;
            r.event_res = EV_STORED;
            r.data_valid = 1'b1;
            r.data_byte = b;
          end
        end
      end
      ACT_RELEASE: begin
        if (rx_status == ST_DONE) rx_status = ST_IDLE;
      end
      ACT_READ: begin
        r.event_res = EV_READ;
        if (ri < DEPTH) begin
          r.data_valid = 1'b1;
          r.data_byte = rx_mem[ri];
        end
      end
      default: ;
    endcase
    r.frame_status = rx_status;
    r.frame_length = 9'(rx_pos);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expectation: tdata %h, tuser %h", m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("frame_status", want.frame_status, m_tdata[1:0]);
        check_field("frame_length", want.frame_length, m_tdata[10:2]);
        check_field("data_byte", want.data_byte, m_tdata[18:11]);
        check_field("tdata padding", 0, m_tdata[23:19]);
        check_field("event_res", want.event_res, m_tuser[2:0]);
        check_field("data_valid", want.data_valid, m_tuser[3]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: stall modes of random length, plus requested long hold-offs
  initial begin
    ready_mode_t mode;
    int phase_left;
    int hold_left;
    int holds_seen;
    int tick;
    mode = RDY_ALWAYS;
    phase_left = 0;
    hold_left = 0;
    holds_seen = 0;
    tick = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (holds_seen != holdoff_requests) begin
        holds_seen = holdoff_requests;
        hold_left = HOLD_CYCLES;
      end
      if (phase_left == 0) begin
        mode = ready_mode_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 200);
      end
      phase_left--;
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          RDY_ALWAYS: m_tready <= 1'b1;
          RDY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
          default:    m_tready <= (tick % 7) < 4;
        endcase
      end
    end
  end

  task automatic send_item(logic [1:0] act, logic [7:0] lb, logic [7:0] ri);
    int gap;
    if (burst_left == 0) begin
      gap = (steady_sender || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {ri, lb};
    s_tuser <= act;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_frame_result(act, lb, ri));
    items_sent++;
  endtask

  task automatic send_line(logic [7:0] b);
    send_item(ACT_LINE, b, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_release();
    send_item(ACT_RELEASE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // only entries already written are read
  task automatic send_read();
    if (rx_filled != 0)
      send_item(ACT_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, rx_filled - 1)));
  endtask

  task automatic send_stuffed(logic [7:0] p);
    if (p == rx_cfg.begin_marker) begin
      send_line(rx_cfg.escape_marker);
      send_line(rx_cfg.begin_substitute);
    end else if (p == rx_cfg.end_marker) begin
      send_line(rx_cfg.escape_marker);
      send_line(rx_cfg.end_substitute);
    end else if (p == rx_cfg.escape_marker) begin
      send_line(rx_cfg.escape_marker);
      send_line(rx_cfg.escape_substitute);
    end else begin
      send_line(p);
    end
  endtask

  task automatic send_frame(int len, bit close);
    send_line(rx_cfg.begin_marker);
    repeat (len) send_stuffed(8'($urandom_range(0, 255)));
    if (close) send_line(rx_cfg.end_marker);
  endtask

  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == rx_cfg.begin_marker || b == rx_cfg.end_marker || b == rx_cfg.escape_marker);
    return b;
  endfunction

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_register(logic [2:0] idx, logic [7:0] val);
    logic [31:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BEGIN_MARKER:      rx_cfg.begin_marker = val;
      REG_END_MARKER:        rx_cfg.end_marker = val;
      REG_ESCAPE_MARKER:     rx_cfg.escape_marker = val;
      REG_BEGIN_SUBSTITUTE:  rx_cfg.begin_substitute = val;
      REG_END_SUBSTITUTE:    rx_cfg.end_substitute = val;
      REG_ESCAPE_SUBSTITUTE: rx_cfg.escape_substitute = val;
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    check_field("prdata", {24'h0, val}, rd);
  endtask

  task automatic apply_setting(setting_t kind);
    cfg_t c;
    case (kind)
      SET_DEFAULT: c = {RST_BEGIN_MARKER, RST_END_MARKER, RST_ESCAPE_MARKER,
                        RST_BEGIN_SUBSTITUTE, RST_END_SUBSTITUTE, RST_ESCAPE_SUBSTITUTE};
      SET_ZEROS:    c = '0;
      SET_ONES:     c = '1;
      SET_EXTREMES: c = {8'h00, 8'hFF, 8'h80, 8'hFF, 8'h00, 8'h7F};
      default: begin
        c.begin_marker = 8'($urandom_range(0, 255));
        do c.end_marker = 8'($urandom_range(0, 255));
        while (c.end_marker == c.begin_marker);
        do c.escape_marker = 8'($urandom_range(0, 255));
        while (c.escape_marker == c.begin_marker || c.escape_marker == c.end_marker);
        c.begin_substitute = 8'($urandom_range(0, 255));
        c.end_substitute = 8'($urandom_range(0, 255));
        c.escape_substitute = 8'($urandom_range(0, 255));
      end
    endcase
    drain_results();
    write_register(REG_BEGIN_MARKER, c.begin_marker);
    write_register(REG_END_MARKER, c.end_marker);
    write_register(REG_ESCAPE_MARKER, c.escape_marker);
    write_register(REG_BEGIN_SUBSTITUTE, c.begin_substitute);
    write_register(REG_END_SUBSTITUTE, c.end_substitute);
    write_register(REG_ESCAPE_SUBSTITUTE, c.escape_substitute);
  endtask

  task automatic send_random_sequence();
    int pick;
    int len;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      len = ($urandom_range(0, 39) == 0) ? $urandom_range(DEPTH - 6, DEPTH + 6)
                                         : $urandom_range(0, 20);
      send_frame(len, $urandom_range(0, 9) != 0);
      repeat ($urandom_range(0, 2)) send_line(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 3)) send_read();
      send_release();
    end else if (pick < 80) begin
      // broken frame: escape followed by an arbitrary code
      send_line(rx_cfg.begin_marker);
      repeat ($urandom_range(0, 8)) send_stuffed(8'($urandom_range(0, 255)));
      send_line(rx_cfg.escape_marker);
      send_line(8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 6)) send_stuffed(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 1) send_line(rx_cfg.end_marker);
    end else if (pick < 95) begin
      repeat ($urandom_range(3, 12)) begin
        n = $urandom_range(0, 9);
        if (n < 4) begin
          send_line(8'($urandom_range(0, 255)));
        end else if (n < 7) begin
          case ($urandom_range(0, 5))
            0: send_line(rx_cfg.begin_marker);
            1: send_line(rx_cfg.end_marker);
            2: send_line(rx_cfg.escape_marker);
            3: send_line(rx_cfg.begin_substitute);
            4: send_line(rx_cfg.end_substitute);
            default: send_line(rx_cfg.escape_substitute);
          endcase
        end else if (n < 8) begin
          send_release();
        end else if (n < 9) begin
          send_read();
        end else begin
          send_item(ACT_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
      end
    end else begin
      repeat ($urandom_range(4, 16)) send_read();
    end
  endtask

  task automatic test_directed_items();
    send_line(8'h00);
    send_line(8'hFF);
    send_line(rx_cfg.end_marker);
    send_line(8'h55);
    send_line(rx_cfg.begin_marker);
    send_item(ACT_READ, 8'hFF, 8'd1);
    send_item(ACT_RELEASE, 8'h00, 8'h00);
    send_item(ACT_RELEASE, 8'hFF, 8'hFF);
    send_item(ACT_UNUSED, 8'hAA, 8'h55);
    send_line(rx_cfg.begin_marker);
    send_line(rx_cfg.escape_marker);
    send_line(rx_cfg.begin_substitute);
    send_line(rx_cfg.escape_marker);
    send_line(rx_cfg.end_substitute);
    send_line(rx_cfg.escape_marker);
    send_line(rx_cfg.escape_substitute);
    send_line(rx_cfg.escape_marker);
    send_line(8'h00);
    send_line(rx_cfg.escape_marker);
    send_line(rx_cfg.begin_marker);
    send_line(rx_cfg.escape_marker);
    send_line(rx_cfg.end_marker);
    send_item(ACT_RELEASE, 8'h00, 8'h00);
    send_line(8'h11);
    send_item(ACT_READ, 8'h00, 8'h00);
  endtask

  task automatic test_overflow();
    send_frame(DEPTH, 1'b0);
    send_line(pick_plain());
    send_line(rx_cfg.escape_marker);
    send_line(pick_plain());
    send_line(rx_cfg.escape_substitute);
    send_line(rx_cfg.end_marker);
    send_release();
    send_item(ACT_READ, 8'h00, 8'hFF);
    send_item(ACT_READ, 8'hFF, 8'h80);
    send_item(ACT_READ, 8'h5A, 8'h00);
    send_frame(3, 1'b1);
    send_release();
  endtask

  task automatic test_register_settings();
    setting_t order [5];
    order = '{SET_ZEROS, SET_ONES, SET_EXTREMES, SET_RANDOM, SET_DEFAULT};
    foreach (order[k]) begin
      apply_setting(order[k]);
      repeat (8) send_random_sequence();
    end
  endtask

  task automatic test_backpressure();
    drain_results();
    steady_sender = 1'b1;
    holdoff_requests++;
    send_frame(30, 1'b1);
    send_release();
    drain_results();
    steady_sender = 1'b0;
  endtask

  task automatic test_random_traffic();
    int start;
    int last_setting;
    start = items_sent;
    last_setting = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (items_sent - last_setting >= 400) begin
        apply_setting(($urandom_range(0, 3) == 0) ? setting_t'($urandom_range(0, 3))
                                                  : SET_RANDOM);
        last_setting = items_sent;
      end
      if ($urandom_range(0, 29) == 0) steady_sender = !steady_sender;
      send_random_sequence();
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    mismatches = 0;
    items_sent = 0;
    burst_left = 0;
    steady_sender = 1'b0;
    holdoff_requests = 0;
    rx_cfg = {RST_BEGIN_MARKER, RST_END_MARKER, RST_ESCAPE_MARKER,
              RST_BEGIN_SUBSTITUTE, RST_END_SUBSTITUTE, RST_ESCAPE_SUBSTITUTE};
    rx_status = ST_IDLE;
    rx_escape = 1'b0;
    rx_pos = 0;
    rx_filled = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_items();
    test_overflow();
    test_register_settings();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
hdl/bsfr_pkg.sv
hdl/bsfr_cfg_regs.sv
hdl/byte_stuffing_frame_receiver.sv
bench/tb_byte_stuffing_frame_receiver.sv
